// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared request codes, character codes and control types for the text
// console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7F;

  // Attribute after reset: white on black
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  // Cell store action decided by the cursor logic for one put beat
  typedef struct packed {
    logic wr_en;     // write one cell
    logic wr_blank;  // write a blank at the new cursor (else the byte at the old one)
    logic scroll;    // the step leaves the bottom row
  } tcw_act_t;

endpackage

// File: rtl/core/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console engine: a cell store of COLUMNS x ROWS cells (attribute
// in the high byte, character in the low byte), a cursor, and put, clear and
// read requests. Each request returns the linear cursor position.
// ----------------------------------------------------------------------------
//  Channel | Signals                                        | Direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, req_type_i, char_code_i, | input
//          | cell_index_i                                   |
//  out     | out_valid_o/out_ready_i, cursor_pos_o,          | output
//          | cell_data_o, scrolled_o                        |
//  cfg     | cfg_we_i, cfg_wdata_i (attribute byte)         | input
//
//  A put without scroll, a read out of range and an unused request answer
//  straight from idle; a read passes the READ state (registered memory read).
//  A scroll copies rows up and blanks the last row, one cell copy or blank per
//  cycle through the single write port; a clear blanks all cells. The input
//  waits while a walk runs or the output register holds an untaken beat. Reset
//  clears the cursor and loads ATTR_RESET; the cell store is not cleared.
// ----------------------------------------------------------------------------
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int TAB_ADVANCE = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] cursor_pos_o,
  output logic [15:0] cell_data_o,
  output logic        scrolled_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = 13;

  localparam logic [AW-1:0] COPY_LEN  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  // State codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_COPY  = 2'd2;
  localparam logic [1:0] S_BLANK = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    attr_q, attr_d;

  logic [10:0]   cursor_pos_q, cursor_pos_d;
  logic [15:0]   cell_data_q, cell_data_d;
  logic          scrolled_q, scrolled_d;

  logic [CW-1:0] put_col;
  logic [RW-1:0] put_row;
  tcw_act_t      put_act;

  logic          accept;
  logic [PW-1:0] pos_cur;
  logic [PW-1:0] pos_put;
  logic [PW-1:0] idx_wide;
  logic          idx_ok;
  logic [15:0]   blank;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   rd_data_q;
  logic [15:0]   mem [CELLS];

  // Byte interpretation and cursor motion
  tcw_cursor #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .TAB_ADVANCE (TAB_ADVANCE)
  ) u_cursor (
    .col_i  (col_q),
    .row_i  (row_q),
    .char_i (char_code_i),
    .col_o  (put_col),
    .row_o  (put_row),
    .act_o  (put_act)
  );

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign pos_cur  = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);
  assign pos_put  = PW'(put_row) * PW'(COLUMNS) + PW'(put_col);
  assign idx_wide = PW'(cell_index_i);
  assign idx_ok   = idx_wide < PW'(CELLS);
  assign blank    = {attr_q, CH_SPACE};

  // Drive the memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_cur[AW-1:0];
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = idx_wide[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept && req_type_i == REQ_PUT && put_act.wr_en) begin
          mem_we = 1'b1;
          if (put_act.wr_blank) begin
            mem_waddr = pos_put[AW-1:0];
          end else begin
            mem_wdata = {attr_q, char_code_i};
          end
        end
        if (accept && req_type_i == REQ_READ && idx_ok) begin
          mem_re = 1'b1;
        end
      end
      S_COPY: begin
        // read one row ahead, write back the cell read last cycle
        mem_re    = (cnt_q != COPY_LEN);
        mem_raddr = AW'((AW+1)'(cnt_q) + (AW+1)'(COLUMNS));
        mem_we    = (cnt_q != '0);
        mem_waddr = cnt_q - AW'(1);
        mem_wdata = rd_data_q;
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Cell store with registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // Sequence requests and walks
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    col_d        = col_q;
    row_d        = row_q;
    out_valid_d  = out_valid_q;
    attr_d       = cfg_we_i ? cfg_wdata_i : attr_q;
    cursor_pos_d = cursor_pos_q;
    cell_data_d  = cell_data_q;
    scrolled_d   = scrolled_q;
    unique case (state_q)
      S_IDLE: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
        end
        if (accept) begin
          cursor_pos_d = pos_cur[10:0];
          cell_data_d  = '0;
          scrolled_d   = 1'b0;
          out_valid_d  = 1'b1;
          case (req_type_i)
            REQ_PUT: begin
              col_d        = put_col;
              row_d        = put_row;
              cursor_pos_d = pos_put[10:0];
              scrolled_d   = put_act.scroll;
              if (put_act.scroll) begin
                out_valid_d = 1'b0;
                cnt_d       = '0;
                state_d     = S_COPY;
              end
            end
            REQ_CLEAR: begin
              col_d        = '0;
              row_d        = '0;
              cursor_pos_d = '0;
              out_valid_d  = 1'b0;
              cnt_d        = '0;
              state_d      = S_BLANK;
            end
            REQ_READ: begin
              if (idx_ok) begin
                out_valid_d = 1'b0;
                state_d     = S_READ;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cell_data_d = rd_data_q;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_COPY: begin
        // hand over to the blank walk over the last row
        if (cnt_q == COPY_LEN) begin
          state_d = S_BLANK;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_BLANK: begin
        if (cnt_q == LAST_CELL) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      attr_q      <= ATTR_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      attr_q      <= attr_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    cursor_pos_q <= cursor_pos_d;
    cell_data_q  <= cell_data_d;
    scrolled_q   <= scrolled_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = cursor_pos_q;
  assign cell_data_o  = cell_data_q;
  assign scrolled_o   = scrolled_q;

endmodule

// File: rtl/core/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor update for one put beat: interprets the byte, computes the next
// column and row, and tells the top level which cell to write.
// ----------------------------------------------------------------------------
module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int TAB_ADVANCE = 5,
  localparam int CW = $clog2(COLUMNS),
  localparam int RW = $clog2(ROWS)
) (
  input  logic [CW-1:0] col_i,
  input  logic [RW-1:0] row_i,
  input  logic [7:0]    char_i,
  output logic [CW-1:0] col_o,
  output logic [RW-1:0] row_o,
  output tcw_act_t      act_o
);

  logic [CW:0] tab_sum;
  logic [CW:0] inc_sum;
  logic        line_down;

  assign tab_sum = (CW+1)'(col_i) + (CW+1)'(TAB_ADVANCE);
  assign inc_sum = (CW+1)'(col_i) + (CW+1)'(1);

  // Decode the byte and move the cursor
  always_comb begin
    col_o     = col_i;
    row_o     = row_i;
    act_o     = '0;
    line_down = 1'b0;
    unique case (char_i)
      CH_BS: begin
        act_o.wr_en    = 1'b1;
        act_o.wr_blank = 1'b1;
        if (col_i != '0) begin
          col_o = col_i - CW'(1);
        end else if (row_i != '0) begin
          row_o = row_i - RW'(1);
          col_o = CW'(COLUMNS - 1);
        end
      end
      CH_TAB: begin
        if (tab_sum >= (CW+1)'(COLUMNS)) begin
          col_o     = CW'(tab_sum - (CW+1)'(COLUMNS));
          line_down = 1'b1;
        end else begin
          col_o = CW'(tab_sum);
        end
      end
      CH_CR: begin
        col_o = '0;
      end
      CH_LF: begin
        col_o     = '0;
        line_down = 1'b1;
      end
      default: begin
        if (char_i >= CH_SPACE && char_i <= CH_LAST) begin
          act_o.wr_en = 1'b1;
          if (inc_sum >= (CW+1)'(COLUMNS)) begin
            col_o     = '0;
            line_down = 1'b1;
          end else begin
            col_o = CW'(inc_sum);
          end
        end
      end
    endcase

    // Step down a row, or flag a scroll at the bottom
    if (line_down) begin
      if (row_i == RW'(ROWS - 1)) begin
        act_o.scroll = 1'b1;
      end else begin
        row_o = row_i + RW'(1);
      end
    end
  end

endmodule
